/* rtl/sirf_pkg.sv */
// Shared constants and types for the signed integer radix formatter.
package sirf_pkg;

   // Default values for the top-level parameters.
   localparam int MAX_SYMBOLS_DEF  = 64;
   localparam int DIGIT_DEPTH_DEF  = 32;
   localparam int NUMBER_WIDTH_DEF = 32;

   // Alphabet storage: eight 64-bit words of eight byte symbols each.
   localparam int ALPHA_WORDS  = 8;
   localparam int WORD_WIDTH   = 64;
   localparam int ALPHA_SYMS   = ALPHA_WORDS * 8;
   localparam int SYM_IDX_W    = $clog2(ALPHA_SYMS);
   localparam int WORD_IDX_W   = $clog2(ALPHA_WORDS);
   localparam int DIGIT_WIDTH  = 6;
   localparam int SYMBOL_WIDTH = 7;
   localparam int CSR_INDEX_W  = 8;
   localparam int QUEUE_DEPTH  = 2;
   localparam int MIN_RADIX    = 2;

   // Character codes.
   localparam logic [7:0] SYM_LOW   = 8'd32;
   localparam logic [7:0] SYM_HIGH  = 8'd126;
   localparam logic [7:0] SYM_PLUS  = 8'h2B;
   localparam logic [7:0] SYM_MINUS = 8'h2D;
   localparam logic [7:0] SYM_ZERO  = 8'h30;
   localparam logic [7:0] SYM_END   = 8'h00;

   typedef logic [7:0] alpha_sym_type;
   typedef alpha_sym_type [ALPHA_SYMS-1:0] alphabet_type;

endpackage

/* rtl/sirf_front.sv */
// Front part: accepts numbers, checks the alphabet and classifies each item.
module sirf_front #(
   parameter int MAX_SYMBOLS  = sirf_pkg::MAX_SYMBOLS_DEF,
   parameter int NUMBER_WIDTH = sirf_pkg::NUMBER_WIDTH_DEF,
   parameter int RAD_W        = $clog2(MAX_SYMBOLS + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [NUMBER_WIDTH-1:0]    req_number,
   output logic                       busy,
   input  sirf_pkg::alphabet_type     alphabet,
   output logic                       push_valid,
   input  logic                       push_full,
   output logic                       push_zero,
   output logic                       push_neg,
   output logic [RAD_W-1:0]           push_radix,
   output logic [NUMBER_WIDTH-1:0]    push_mag
);
   import sirf_pkg::*;

   typedef enum logic [1:0] {
      F_IDLE,
      F_SCAN,
      F_PUSH
   } front_state_type;

   front_state_type           state_ff, state_in;
   logic [NUMBER_WIDTH-1:0]   number_ff, number_in;
   logic [RAD_W-1:0]          count_ff, count_in;
   alpha_sym_type             cur_sym;
   logic                      scan_end;
   logic                      dup;
   logic                      bad;

   // The symbol under inspection and whether the alphabet ends here.
   assign cur_sym  = alphabet[SYM_IDX_W'(count_ff)];
   assign scan_end = (count_ff == RAD_W'(MAX_SYMBOLS)) || (cur_sym == SYM_END);

   // Compare the current symbol with every earlier one in parallel.
   always_comb begin
      dup = 1'b0;
      for (int j = 0; j < ALPHA_SYMS; j++) begin
         if ((j < int'(count_ff)) && (alphabet[j] == cur_sym)) begin
            dup = 1'b1;
         end
      end
   end

   assign bad = (cur_sym == SYM_PLUS) || (cur_sym == SYM_MINUS) ||
                (cur_sym < SYM_LOW) || (cur_sym > SYM_HIGH) || dup;

   // Next-state logic: one symbol is checked per cycle.
   always_comb begin
      state_in  = state_ff;
      number_in = number_ff;
      count_in  = count_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               number_in = req_number;
               count_in  = '0;
               state_in  = (req_number == '0) ? F_PUSH : F_SCAN;
            end
         end
         F_SCAN: begin
            if (scan_end) begin
               // Fewer than two symbols means the alphabet is unusable.
               state_in = (count_ff >= RAD_W'(MIN_RADIX)) ? F_PUSH : F_IDLE;
            end else if (bad) begin
               state_in = F_IDLE;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         F_PUSH: begin
            if (!push_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // State and captured item.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      number_ff <= number_in;
      count_ff  <= count_in;
   end

   // Classification handed to the queue.
   assign busy       = (state_ff != F_IDLE);
   assign push_valid = (state_ff == F_PUSH);
   assign push_zero  = (number_ff == '0);
   assign push_neg   = number_ff[NUMBER_WIDTH-1];
   assign push_radix = count_ff;
   assign push_mag   = number_ff[NUMBER_WIDTH-1] ? (~number_ff + 1'b1) : number_ff;

endmodule

/* rtl/sirf_queue.sv */
// Short queue of classified items between the front and back parts.
module sirf_queue #(
   parameter int DATA_W = 40
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);
   import sirf_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push_valid && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/sirf_back.sv */
// Back part: divides out the digits with a bit-serial divider and emits characters.
module sirf_back #(
   parameter int MAX_SYMBOLS  = sirf_pkg::MAX_SYMBOLS_DEF,
   parameter int DIGIT_DEPTH  = sirf_pkg::DIGIT_DEPTH_DEF,
   parameter int NUMBER_WIDTH = sirf_pkg::NUMBER_WIDTH_DEF,
   parameter int RAD_W        = $clog2(MAX_SYMBOLS + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sirf_pkg::alphabet_type                alphabet,
   input  logic                                  q_empty,
   output logic                                  q_pop,
   input  logic                                  q_zero,
   input  logic                                  q_neg,
   input  logic [RAD_W-1:0]                      q_radix,
   input  logic [NUMBER_WIDTH-1:0]               q_mag,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sirf_pkg::SYMBOL_WIDTH-1:0]     rsp_symbol,
   output logic                                  rsp_last
);
   import sirf_pkg::*;

   localparam int IDX_W = $clog2(DIGIT_DEPTH);
   localparam int CNT_W = $clog2(DIGIT_DEPTH + 1);
   localparam int BIT_W = $clog2(NUMBER_WIDTH);

   typedef enum logic [2:0] {
      B_IDLE,
      B_ZERO,
      B_DIV,
      B_SIGN,
      B_READ,
      B_EMIT
   } back_state_type;

   back_state_type              state_ff, state_in;
   logic [NUMBER_WIDTH-1:0]     quot_ff, quot_in;
   logic [RAD_W-1:0]            rem_ff, rem_in;
   logic [RAD_W-1:0]            radix_ff, radix_in;
   logic                        neg_ff, neg_in;
   logic [BIT_W-1:0]            bit_ff, bit_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [SYMBOL_WIDTH-1:0]     rsp_symbol_ff, rsp_symbol_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [DIGIT_WIDTH-1:0]      stack_mem [DIGIT_DEPTH];
   logic [DIGIT_WIDTH-1:0]      rd_data_ff;
   logic                        wr_en;
   logic                        rd_en;
   logic [CNT_W-1:0]            cnt_dec;

   logic [RAD_W:0]              shifted;
   logic                        ge;
   logic [RAD_W-1:0]            rem_step;
   logic [NUMBER_WIDTH-1:0]     quot_step;
   logic                        slot_free;

   // One restoring division step: bring in the next bit of the dividend.
   assign shifted   = {rem_ff, quot_ff[NUMBER_WIDTH-1]};
   assign ge        = (shifted >= {1'b0, radix_ff});
   assign rem_step  = ge ? RAD_W'(shifted - {1'b0, radix_ff}) : RAD_W'(shifted);
   assign quot_step = {quot_ff[NUMBER_WIDTH-2:0], ge};

   assign cnt_dec   = cnt_ff - 1'b1;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer for division, sign and digit output.
   always_comb begin
      state_in      = state_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      radix_in      = radix_ff;
      neg_in        = neg_ff;
      bit_in        = bit_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               quot_in  = q_mag;
               radix_in = q_radix;
               neg_in   = q_neg;
               rem_in   = '0;
               bit_in   = BIT_W'(NUMBER_WIDTH - 1);
               cnt_in   = '0;
               state_in = q_zero ? B_ZERO : B_DIV;
            end
         end
         B_ZERO: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = SYMBOL_WIDTH'(SYM_ZERO);
               rsp_last_in   = 1'b1;
               state_in      = B_IDLE;
            end
         end
         B_DIV: begin
            quot_in = quot_step;
            rem_in  = rem_step;
            bit_in  = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               // A digit is complete: push it, then start the next one or finish.
               wr_en  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               rem_in = '0;
               bit_in = BIT_W'(NUMBER_WIDTH - 1);
               if ((quot_step == '0) || (cnt_ff + 1'b1 == CNT_W'(DIGIT_DEPTH))) begin
                  state_in = neg_ff ? B_SIGN : B_READ;
               end
            end
         end
         B_SIGN: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = SYMBOL_WIDTH'(SYM_MINUS);
               rsp_last_in   = 1'b0;
               state_in      = B_READ;
            end
         end
         B_READ: begin
            rd_en    = 1'b1;
            cnt_in   = cnt_dec;
            state_in = B_EMIT;
         end
         B_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = SYMBOL_WIDTH'(alphabet[rd_data_ff]);
               rsp_last_in   = (cnt_ff == '0);
               state_in      = (cnt_ff == '0) ? B_IDLE : B_READ;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      radix_ff      <= radix_in;
      neg_ff        <= neg_in;
      bit_ff        <= bit_in;
      cnt_ff        <= cnt_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Digit stack, least significant digit at the bottom.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[cnt_ff[IDX_W-1:0]] <= DIGIT_WIDTH'(rem_step);
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem[cnt_dec[IDX_W-1:0]];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

/* rtl/signed_integer_radix_formatter.sv */
// Top level of the signed integer radix formatter.
//
// Numbers enter on the req_ channel (req_valid, req_stall, req_number) and
// leave as ASCII characters on the rsp_ channel (rsp_valid, rsp_stall,
// rsp_symbol, rsp_last); rsp_last marks the final character of a number.
// The digit alphabet is written through the csr_ port (csr_index 0 to 7,
// 64-bit csr_data); the user must write it only while the block is idle,
// which the block itself does not enforce. The radix is the symbol count.
// A zero input gives a single '0'. A nonzero input with an invalid alphabet
// gives nothing; otherwise an optional '-' and the digits, most significant first.
// The front part checks the alphabet at one symbol per cycle and then hands
// the item to a two-entry queue, so it can take the next number while the
// back part works.
// The back part owns a bit-serial divider that runs over every dividend bit
// for each digit, then reads the digits back from its stack as characters.
// That divider, or the alphabet check in the front part, sets the throughput.
// Reset clears the alphabet to empty, empties the queue and drops any pending
// output. A stalled result beat holds on the rsp_ port; the back part then waits
// to emit, and the front part and queue accept numbers until the queue is full.
module signed_integer_radix_formatter #(
   parameter int MAX_SYMBOLS  = sirf_pkg::MAX_SYMBOLS_DEF,
   parameter int DIGIT_DEPTH  = sirf_pkg::DIGIT_DEPTH_DEF,
   parameter int NUMBER_WIDTH = sirf_pkg::NUMBER_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [NUMBER_WIDTH-1:0]        req_number,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sirf_pkg::SYMBOL_WIDTH-1:0]     rsp_symbol,
   output logic                                  rsp_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sirf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [sirf_pkg::WORD_WIDTH-1:0]       csr_data
);
   import sirf_pkg::*;

   localparam int RAD_W  = $clog2(MAX_SYMBOLS + 1);
   localparam int DATA_W = 2 + RAD_W + NUMBER_WIDTH;

   logic [WORD_WIDTH-1:0]   alpha_word_ff [ALPHA_WORDS];
   alphabet_type            alphabet;
   logic                    front_busy;
   logic                    push_valid;
   logic                    push_full;
   logic                    push_zero;
   logic                    push_neg;
   logic [RAD_W-1:0]        push_radix;
   logic [NUMBER_WIDTH-1:0] push_mag;
   logic [DATA_W-1:0]       push_data;
   logic [DATA_W-1:0]       pop_data;
   logic                    q_pop;
   logic                    q_empty;

   // Alphabet registers.
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < ALPHA_WORDS; w++) begin
            alpha_word_ff[w] <= '0;
         end
      end else if (csr_valid && (csr_index < CSR_INDEX_W'(ALPHA_WORDS))) begin
         alpha_word_ff[csr_index[WORD_IDX_W-1:0]] <= csr_data;
      end
   end

   // Unpack the words into byte symbols, byte 0 first.
   always_comb begin
      for (int w = 0; w < ALPHA_WORDS; w++) begin
         for (int b = 0; b < 8; b++) begin
            alphabet[w * 8 + b] = alpha_word_ff[w][b * 8 +: 8];
         end
      end
   end

   assign req_stall = reset || front_busy;

   sirf_front #(
      .MAX_SYMBOLS  (MAX_SYMBOLS),
      .NUMBER_WIDTH (NUMBER_WIDTH),
      .RAD_W        (RAD_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid && !reset),
      .req_number (req_number),
      .busy       (front_busy),
      .alphabet   (alphabet),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_zero  (push_zero),
      .push_neg   (push_neg),
      .push_radix (push_radix),
      .push_mag   (push_mag)
   );

   assign push_data = {push_zero, push_neg, push_radix, push_mag};

   sirf_queue #(
      .DATA_W (DATA_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (push_full),
      .pop        (q_pop),
      .pop_data   (pop_data),
      .empty      (q_empty)
   );

   sirf_back #(
      .MAX_SYMBOLS  (MAX_SYMBOLS),
      .DIGIT_DEPTH  (DIGIT_DEPTH),
      .NUMBER_WIDTH (NUMBER_WIDTH),
      .RAD_W        (RAD_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .alphabet   (alphabet),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .q_zero     (pop_data[DATA_W-1]),
      .q_neg      (pop_data[DATA_W-2]),
      .q_radix    (pop_data[NUMBER_WIDTH +: RAD_W]),
      .q_mag      (pop_data[NUMBER_WIDTH-1:0]),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last)
   );

endmodule

/* rtl/sirf_checker.sv */
// Port-level checks for the signed integer radix formatter, bound to the top level.
module sirf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [sirf_pkg::SYMBOL_WIDTH-1:0] rsp_symbol,
   input logic                              rsp_last
);
   import sirf_pkg::*;

   // Reset empties the output register.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat pending after reset");

   // A stalled result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_symbol) && $stable(rsp_last))
      else $error("stalled result beat changed");

   // Only printable characters leave the block.
   a_printable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_symbol >= SYMBOL_WIDTH'(SYM_LOW)) &&
                    (rsp_symbol <= SYMBOL_WIDTH'(SYM_HIGH)))
      else $error("result symbol outside printable range");

   // A minus sign is always followed by at least one digit.
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_symbol == SYMBOL_WIDTH'(SYM_MINUS)) |-> !rsp_last)
      else $error("minus sign flagged as last character");

   // The front part is still busy in the cycle after it takes a number.
   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("front part took two numbers back to back");

endmodule

bind signed_integer_radix_formatter sirf_checker u_sirf_checker (.*);
